// ----- rtl/kts_pkg.sv -----
// Package for the key tally table: default sizes, request and result types,
// operation codes and sequencer states. It depends on nothing else.
`default_nettype none

package kts_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int KEY_BYTES_DEF     = 16;
  localparam int TALLY_BITS_DEF    = 16;
  localparam int OUT_TALLY_W       = 16;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [63:0] key_low;
    logic [63:0] key_high;
  } in_req_t;

  typedef struct packed {
    logic [63:0]            out_key_low;
    logic [63:0]            out_key_high;
    logic [OUT_TALLY_W-1:0] tally;
    logic                   entry_valid;
    logic                   last_entry;
    logic                   keys_dropped;
  } out_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC_RD,
    S_REC_CMP,
    S_REC_NEW,
    S_SRT_LD,
    S_SRT_HOLD,
    S_SRT_RD,
    S_SRT_CMP,
    S_SRT_PUT,
    S_OUT_RD,
    S_OUT_SEND
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/key_tally_table_sorted_readout.sv -----
// Top level of the key tally table with sorted readout: entry memory, one
// compare unit and the sequencer that walks, sorts and reads out the table.
// Depends on kts_pkg.
//
//   channel  ports                      handshake
//   request  in_req, start, busy        taken when start is high and busy is low
//   result   out_res, out_valid         one cycle per result, no back pressure
//
// Every record reads and compares the entries in turn through a read state and a
// compare state; a miss adds an append state, which sets the drop flag instead
// when the table is full. A finish over n entries runs an insertion sort with
// load, hold and put states per insertion and read and compare states per
// compare, then sends each result through a read state and a send state, so
// readout results never come in consecutive cycles. A finish on an empty table
// answers in the next cycle without going busy. Reset empties the table and
// clears the drop flag; results cannot be stalled.
`default_nettype none

module key_tally_table_sorted_readout #(
  parameter int TABLE_ENTRIES = kts_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BYTES     = kts_pkg::KEY_BYTES_DEF,
  parameter int TALLY_BITS    = kts_pkg::TALLY_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  kts_pkg::in_req_t  in_req,
  input  wire              start,
  output logic             busy,
  output kts_pkg::out_res_t out_res,
  output logic             out_valid
);

  localparam int IW    = $clog2(TABLE_ENTRIES);
  localparam int CW    = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = 128 + TALLY_BITS;
  localparam logic [63:0] MASK_LO = (KEY_BYTES >= 8) ? {64{1'b1}} :
                                    ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
  localparam logic [63:0] MASK_HI = (KEY_BYTES <= 8) ? 64'd0 :
                                    (KEY_BYTES >= 16) ? {64{1'b1}} :
                                    ((64'd1 << (8 * (KEY_BYTES - 8))) - 64'd1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

  logic [ENT_W-1:0] ent_mem_r [TABLE_ENTRIES];
  logic [ENT_W-1:0] mem_rd_r;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [IW-1:0]    mem_raddr;
  logic [ENT_W-1:0] mem_wdata;

  kts_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [127:0]      key_r, key_nxt;
  logic [ENT_W-1:0]  hold_r, hold_nxt;
  kts_pkg::out_res_t out_res_r, out_res_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [127:0]          rd_key;
  logic [TALLY_BITS-1:0] rd_tally;
  logic [TALLY_BITS-1:0] rd_tally_inc;
  logic [31:0]           rd_tally_wide;
  logic [CW-1:0]         idx_inc;
  logic [CW-1:0]         j_dec;

  assign rd_key        = mem_rd_r[ENT_W-1:TALLY_BITS];
  assign rd_tally      = mem_rd_r[TALLY_BITS-1:0];
  assign rd_tally_inc  = (rd_tally == {TALLY_BITS{1'b1}}) ? rd_tally :
                         rd_tally + TALLY_BITS'(1);
  assign rd_tally_wide = 32'(rd_tally);
  assign idx_inc       = idx_r + CW'(1);
  assign j_dec         = j_r - CW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ent_mem_r[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= ent_mem_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kts_pkg::S_IDLE;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    hold_r    <= hold_nxt;
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    key_nxt       = key_r;
    hold_nxt      = hold_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[IW-1:0];
    mem_raddr     = idx_r[IW-1:0];
    mem_wdata     = hold_r;

    unique case (state_r)
      kts_pkg::S_IDLE: begin
        if (start) begin
          key_nxt = {in_req.key_high & MASK_HI, in_req.key_low & MASK_LO};
          idx_nxt = '0;
          if (in_req.operation == kts_pkg::OP_RECORD) begin
            state_nxt = (used_r == '0) ? kts_pkg::S_REC_NEW : kts_pkg::S_REC_RD;
          end else if (used_r == '0) begin
            out_res_nxt.out_key_low  = '0;
            out_res_nxt.out_key_high = '0;
            out_res_nxt.tally        = '0;
            out_res_nxt.entry_valid  = 1'b0;
            out_res_nxt.last_entry   = 1'b1;
            out_res_nxt.keys_dropped = ovf_r;
            out_valid_nxt            = 1'b1;
            ovf_nxt                  = 1'b0;
          end else if (used_r == CW'(1)) begin
            state_nxt = kts_pkg::S_OUT_RD;
          end else begin
            idx_nxt   = CW'(1);
            state_nxt = kts_pkg::S_SRT_LD;
          end
        end
      end
      kts_pkg::S_REC_RD: begin
        state_nxt = kts_pkg::S_REC_CMP;
      end
      kts_pkg::S_REC_CMP: begin
        if (rd_key == key_r) begin
          mem_we    = 1'b1;
          mem_wdata = {rd_key, rd_tally_inc};
          state_nxt = kts_pkg::S_IDLE;
        end else if (idx_inc == used_r) begin
          state_nxt = kts_pkg::S_REC_NEW;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = kts_pkg::S_REC_RD;
        end
      end
      kts_pkg::S_REC_NEW: begin
        if (used_r == FULL) begin
          ovf_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = used_r[IW-1:0];
          mem_wdata = {key_r, TALLY_BITS'(1)};
          used_nxt  = used_r + CW'(1);
        end
        state_nxt = kts_pkg::S_IDLE;
      end
      kts_pkg::S_SRT_LD: begin
        state_nxt = kts_pkg::S_SRT_HOLD;
      end
      kts_pkg::S_SRT_HOLD: begin
        hold_nxt  = mem_rd_r;
        j_nxt     = idx_r;
        state_nxt = kts_pkg::S_SRT_RD;
      end
      kts_pkg::S_SRT_RD: begin
        mem_raddr = j_dec[IW-1:0];
        state_nxt = kts_pkg::S_SRT_CMP;
      end
      kts_pkg::S_SRT_CMP: begin
        if (rd_tally < hold_r[TALLY_BITS-1:0]) begin
          mem_we    = 1'b1;
          mem_waddr = j_r[IW-1:0];
          mem_wdata = mem_rd_r;
          j_nxt     = j_dec;
          state_nxt = (j_dec == '0) ? kts_pkg::S_SRT_PUT : kts_pkg::S_SRT_RD;
        end else begin
          state_nxt = kts_pkg::S_SRT_PUT;
        end
      end
      kts_pkg::S_SRT_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[IW-1:0];
        mem_wdata = hold_r;
        if (idx_inc == used_r) begin
          idx_nxt   = '0;
          state_nxt = kts_pkg::S_OUT_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = kts_pkg::S_SRT_LD;
        end
      end
      kts_pkg::S_OUT_RD: begin
        state_nxt = kts_pkg::S_OUT_SEND;
      end
      kts_pkg::S_OUT_SEND: begin
        out_res_nxt.out_key_low  = rd_key[63:0];
        out_res_nxt.out_key_high = rd_key[127:64];
        out_res_nxt.tally        = rd_tally_wide[kts_pkg::OUT_TALLY_W-1:0];
        out_res_nxt.entry_valid  = 1'b1;
        out_res_nxt.last_entry   = (idx_inc == used_r);
        out_res_nxt.keys_dropped = ovf_r;
        out_valid_nxt            = 1'b1;
        if (idx_inc == used_r) begin
          used_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = kts_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = kts_pkg::S_OUT_RD;
        end
      end
      default: begin
        state_nxt = kts_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != kts_pkg::S_IDLE);
  assign out_res   = out_res_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/kts_check.sv -----
// Port-level checker for the key tally table and its bind to the top level.
// Depends on kts_pkg and key_tally_table_sorted_readout.
`default_nettype none

module kts_check (
  input wire               clk,
  input wire               rst_n,
  input kts_pkg::in_req_t  in_req,
  input wire               start,
  input wire               busy,
  input kts_pkg::out_res_t out_res,
  input wire               out_valid
);

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.operation == kts_pkg::OP_RECORD) |=> !out_valid)
    else $error("A record request produced a result.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.operation == kts_pkg::OP_FINISH) |=> (out_valid || busy))
    else $error("A finish request neither answered nor started a readout.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.entry_valid) |-> out_res.last_entry)
    else $error("An empty-table result was not marked last.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last_entry) |-> busy)
    else $error("The block went idle in the middle of a readout.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last_entry) |=> !out_valid)
    else $error("Readout results came in consecutive cycles.");

endmodule

bind key_tally_table_sorted_readout kts_check u_kts_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_req    (in_req),
  .start     (start),
  .busy      (busy),
  .out_res   (out_res),
  .out_valid (out_valid)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for key_tally_table_sorted_readout: directed and random
// record and finish requests, a predictor of the tally table and its sorted readout.
// Depends on kts_pkg and the key_tally_table_sorted_readout RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int          SLOTS      = kts_pkg::TABLE_ENTRIES_DEF;
  localparam logic [31:0] TALLY_MAX  = (32'd1 << kts_pkg::TALLY_BITS_DEF) - 32'd1;
  localparam int          DRAIN_CYC  = 200;
  localparam int          RAND_ITEMS = 125;

  typedef struct {
    kts_pkg::in_req_t req;
    int unsigned      gap;
  } pending_req_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  kts_pkg::in_req_t  in_req = '0;
  logic              start = 1'b0;
  logic              busy;
  kts_pkg::out_res_t out_res;
  logic              out_valid;

  pending_req_t      pending_reqs[$];
  pending_req_t      next_req;
  kts_pkg::out_res_t readout_q[$];
  int unsigned       idle_cnt;

  logic [63:0] tbl_key_low[SLOTS];
  logic [63:0] tbl_key_high[SLOTS];
  logic [31:0] tbl_tally[SLOTS];
  int unsigned used_entries = 0;
  logic        drop_flag = 1'b0;

  int unsigned reqs_taken = 0;
  int unsigned finishes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned overflow_results = 0;
  int unsigned error_count = 0;

  key_tally_table_sorted_readout u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .start     (start),
    .busy      (busy),
    .out_res   (out_res),
    .out_valid (out_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_tally_readout(kts_pkg::in_req_t req);
    int unsigned       slot;
    int unsigned       j;
    bit                hit;
    logic [63:0]       klo;
    logic [63:0]       khi;
    logic [31:0]       t;
    kts_pkg::out_res_t res;
    if (req.operation == kts_pkg::OP_RECORD) begin
      hit = 1'b0;
      for (slot = 0; slot < used_entries; slot++) begin
        if (!hit && tbl_key_low[slot] == req.key_low && tbl_key_high[slot] == req.key_high) begin
          hit = 1'b1;
          if (tbl_tally[slot] < TALLY_MAX) tbl_tally[slot]++;
        end
      end
      if (!hit) begin
        if (used_entries >= SLOTS) begin
          drop_flag = 1'b1;
        end else begin
          tbl_key_low[used_entries]  = req.key_low;
          tbl_key_high[used_entries] = req.key_high;
          tbl_tally[used_entries]    = 32'd1;
          used_entries++;
        end
      end
    end else begin
      if (used_entries == 0) begin
        res = '0;
        res.last_entry   = 1'b1;
        res.keys_dropped = drop_flag;
        readout_q.push_back(res);
      end else begin
        // Stable insertion sort on descending tally keeps first-seen order on ties.
        for (slot = 1; slot < used_entries; slot++) begin
          t   = tbl_tally[slot];
          klo = tbl_key_low[slot];
          khi = tbl_key_high[slot];
          j   = slot;
          while (j > 0 && tbl_tally[j-1] < t) begin
            tbl_tally[j]    = tbl_tally[j-1];
            tbl_key_low[j]  = tbl_key_low[j-1];
            tbl_key_high[j] = tbl_key_high[j-1];
            j--;
          end
          tbl_tally[j]    = t;
          tbl_key_low[j]  = klo;
          tbl_key_high[j] = khi;
        end
        for (slot = 0; slot < used_entries; slot++) begin
          res.out_key_low  = tbl_key_low[slot];
          res.out_key_high = tbl_key_high[slot];
          res.tally        = tbl_tally[slot][kts_pkg::OUT_TALLY_W-1:0];
          res.entry_valid  = 1'b1;
          res.last_entry   = (slot + 1 == used_entries);
          res.keys_dropped = drop_flag;
          readout_q.push_back(res);
        end
      end
      used_entries = 0;
      drop_flag    = 1'b0;
    end
  endfunction

  // Request driver: holds a request until taken, then waits the next one's gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_cnt = 0;
    end else if (!start || !busy) begin
      if (start) begin
        predict_tally_readout(in_req);
        reqs_taken++;
        if (in_req.operation == kts_pkg::OP_FINISH) finishes_taken++;
      end
      if (pending_reqs.size() != 0 && idle_cnt >= pending_reqs[0].gap) begin
        next_req = pending_reqs.pop_front();
        in_req <= next_req.req;
        start  <= 1'b1;
        idle_cnt = 0;
      end else begin
        start <= 1'b0;
        idle_cnt++;
      end
    end
  end

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    error_count++;
    if (error_count <= 10)
      $display("Mismatch on %s at result %0d: expected %h, got %h",
               field, results_seen, want, got);
  endtask

  // Result monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    kts_pkg::out_res_t want;
    if (rst_n && out_valid) begin
      if (readout_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("Unexpected result with key %h_%h, tally %0d",
                   out_res.out_key_high, out_res.out_key_low, out_res.tally);
      end else begin
        want = readout_q.pop_front();
        if (out_res.out_key_low !== want.out_key_low)
          report_mismatch("out_key_low", want.out_key_low, out_res.out_key_low);
        if (out_res.out_key_high !== want.out_key_high)
          report_mismatch("out_key_high", want.out_key_high, out_res.out_key_high);
        if (out_res.tally !== want.tally)
          report_mismatch("tally", 64'(want.tally), 64'(out_res.tally));
        if (out_res.entry_valid !== want.entry_valid)
          report_mismatch("entry_valid", 64'(want.entry_valid), 64'(out_res.entry_valid));
        if (out_res.last_entry !== want.last_entry)
          report_mismatch("last_entry", 64'(want.last_entry), 64'(out_res.last_entry));
        if (out_res.keys_dropped !== want.keys_dropped)
          report_mismatch("keys_dropped", 64'(want.keys_dropped), 64'(out_res.keys_dropped));
        if (want.keys_dropped) overflow_results++;
      end
      results_seen++;
    end
  end

  task automatic push_req(kts_pkg::op_t op, logic [63:0] lo, logic [63:0] hi,
                          int unsigned gap);
    pending_req_t p;
    p.req.operation = op;
    p.req.key_low   = lo;
    p.req.key_high  = hi;
    p.gap           = gap;
    pending_reqs.push_back(p);
  endtask

  function automatic int unsigned draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  initial begin
    logic [63:0] pool_lo[64];
    logic [63:0] pool_hi[64];
    int unsigned pool_n;
    int unsigned n_rec;
    int unsigned idx;
    int unsigned rand_sent;
    int unsigned i;
    bit          long_phase;
    bit          quiet;

    // Directed: empty finish, zero and all-ones keys, ties in first-seen order.
    push_req(kts_pkg::OP_FINISH, '0, '0, draw_gap(0));
    push_req(kts_pkg::OP_RECORD, '0, '0, draw_gap(0));
    push_req(kts_pkg::OP_RECORD, '1, '1, draw_gap(0));
    push_req(kts_pkg::OP_RECORD, 64'h0123_4567_89ab_cdef, '0, draw_gap(0));
    push_req(kts_pkg::OP_RECORD, '1, '1, draw_gap(0));
    push_req(kts_pkg::OP_RECORD, '0, 64'hfedc_ba98_7654_3210, draw_gap(0));
    push_req(kts_pkg::OP_FINISH, '1, '1, draw_gap(0));
    push_req(kts_pkg::OP_RECORD, '0, '0, draw_gap(0));
    push_req(kts_pkg::OP_FINISH, '0, '0, draw_gap(0));

    // Directed: fill the table past its size, hit while full, then a finish and an empty finish.
    for (i = 0; i < SLOTS + 3; i++) begin
      pool_lo[i] = {$urandom, 32'(i)};
      pool_hi[i] = {$urandom, $urandom};
      push_req(kts_pkg::OP_RECORD, pool_lo[i], pool_hi[i], draw_gap(1));
    end
    push_req(kts_pkg::OP_RECORD, pool_lo[0], pool_hi[0], draw_gap(1));
    push_req(kts_pkg::OP_RECORD, pool_lo[7], pool_hi[7], draw_gap(1));
    push_req(kts_pkg::OP_RECORD, pool_lo[7], pool_hi[7], draw_gap(1));
    push_req(kts_pkg::OP_RECORD, pool_lo[SLOTS-1], pool_hi[SLOTS-1], draw_gap(1));
    push_req(kts_pkg::OP_FINISH, '0, '0, draw_gap(0));
    push_req(kts_pkg::OP_FINISH, '0, '0, draw_gap(0));

    // Random phases: records from a key pool, larger than the table in long phases, closed by a finish.
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      long_phase = ($urandom_range(0, 4) == 0);
      quiet      = ($urandom_range(0, 3) == 0);
      pool_n     = long_phase ? $urandom_range(SLOTS + 1, SLOTS + 12) : $urandom_range(1, 20);
      n_rec      = long_phase ? $urandom_range(5, 25) : $urandom_range(0, 25);
      for (i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 7))
          0:       begin pool_lo[i] = '0; pool_hi[i] = '0; end
          1:       begin pool_lo[i] = '1; pool_hi[i] = '1; end
          default: begin
            pool_lo[i] = {$urandom, $urandom};
            pool_hi[i] = {$urandom, $urandom};
          end
        endcase
        if (long_phase) begin
          push_req(kts_pkg::OP_RECORD, pool_lo[i], pool_hi[i], draw_gap(quiet));
          rand_sent++;
        end
      end
      for (i = 0; i < n_rec; i++) begin
        if ($urandom_range(0, 1) == 0) idx = $urandom_range(0, (pool_n > 4) ? 3 : pool_n - 1);
        else idx = $urandom_range(0, pool_n - 1);
        push_req(kts_pkg::OP_RECORD, pool_lo[idx], pool_hi[idx], draw_gap(quiet));
        rand_sent++;
      end
      push_req(kts_pkg::OP_FINISH, {$urandom, $urandom}, {$urandom, $urandom},
               draw_gap(quiet));
      rand_sent++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending_reqs.size() != 0 || start);
    while (readout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (readout_q.size() != 0) begin
      error_count += readout_q.size();
      $display("%0d expected results never arrived", readout_q.size());
    end
    $display("Ran %0d requests with %0d finishes; checked %0d results.",
             reqs_taken, finishes_taken, results_seen);
    $display("%0d results followed a table overflow.", overflow_results);
    if (error_count == 0) begin
      $display("key_tally_table_sorted_readout test passed");
    end else begin
      $display("key_tally_table_sorted_readout test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d requests pending and %0d results outstanding",
             pending_reqs.size(), readout_q.size());
    $display("key_tally_table_sorted_readout test failed");
    $finish;
  end

endmodule
